// ===== design/obpl_pkg.sv =====
// Shared types, codes and default sizes for the order book price level block.
package obpl_pkg;

    localparam int LEVELS_DEF     = 64;
    localparam int PRICE_BITS_DEF = 32;
    localparam int QTY_BITS_DEF   = 32;
    localparam int FIELD_W        = 32;

    typedef enum logic [1:0] {
        FN_ADD     = 2'd0,
        FN_DELETE  = 2'd1,
        FN_CANCEL  = 2'd2,
        FN_REPLACE = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2
    } status_t;

    localparam logic SIDE_BID = 1'b0;
    localparam logic SIDE_ASK = 1'b1;

    typedef struct packed {
        func_t              func;
        logic               order_side;
        logic [FIELD_W-1:0] order_price;
        logic [FIELD_W-1:0] order_qty;
        logic [FIELD_W-1:0] cancel_qty;
        logic               new_side;
        logic [FIELD_W-1:0] new_price;
        logic [FIELD_W-1:0] new_qty;
    } order_t;

    typedef struct packed {
        status_t            status;
        logic [FIELD_W-1:0] remaining_qty;
        logic [FIELD_W-1:0] level_qty;
        logic [FIELD_W-1:0] best_bid_price;
        logic [FIELD_W-1:0] best_bid_qty;
        logic [FIELD_W-1:0] best_ask_price;
        logic [FIELD_W-1:0] best_ask_qty;
    } book_t;

    // command broadcast to every cell of one side
    typedef struct packed {
        logic en;
        logic add;
        logic drop;
    } obpl_cmd_t;

    // lookup result of one side
    typedef struct packed {
        logic found;
        logic full;
    } obpl_look_t;

endpackage

// ===== design/order_book_price_levels.sv =====
// Order book price level aggregation: top level with sequencer and result register.
// An accepted order goes through S_OP1 (and S_OP2 for replace) to S_DONE, then into the output register.
// Orders do not overlap, and book_stall can hold S_DONE; replace is two cell-chain updates, others one.
// The next order is taken in the cycle its predecessor's result is loaded into the output register.
// Reset empties both sides (all cell valid bits cleared) and the output register.
module order_book_price_levels
    import obpl_pkg::*;
#(
    parameter int LEVELS     = LEVELS_DEF,
    parameter int PRICE_BITS = PRICE_BITS_DEF,
    parameter int QTY_BITS   = QTY_BITS_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   order_valid,
    output logic   order_stall,
    input  order_t order,
    output logic   book_valid,
    input  logic   book_stall,
    output book_t  book
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_OP1,
        S_OP2,
        S_DONE
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    order_t                item_reg;
    logic                  book_valid_reg;
    logic                  book_valid_next;
    book_t                 book_reg;
    book_t                 book_next;
    status_t               res_status_reg;
    status_t               res_status_next;
    logic [QTY_BITS-1:0]   res_lvl_reg;
    logic [QTY_BITS-1:0]   res_lvl_next;
    logic [QTY_BITS-1:0]   res_rem_reg;
    logic [QTY_BITS-1:0]   res_rem_next;

    logic                  accept;
    logic                  load_out;
    logic                  first;
    logic                  second;

    logic [PRICE_BITS-1:0] o_price;
    logic [QTY_BITS-1:0]   o_qty;
    logic [QTY_BITS-1:0]   c_qty;
    logic [PRICE_BITS-1:0] n_price;
    logic [QTY_BITS-1:0]   n_qty;
    logic                  part_cancel;

    logic                  cur_add;
    logic                  cur_side;
    logic [PRICE_BITS-1:0] cur_price;
    logic [QTY_BITS-1:0]   cur_amt;
    logic                  cur_drop;
    status_t               cur_status;
    logic [QTY_BITS-1:0]   cur_lvl;
    logic [QTY_BITS:0]     sum;
    logic [QTY_BITS-1:0]   sat;

    obpl_cmd_t             bid_cmd;
    obpl_cmd_t             ask_cmd;
    obpl_look_t            bid_look;
    obpl_look_t            ask_look;
    obpl_look_t            look;
    logic [QTY_BITS-1:0]   bid_mq;
    logic [QTY_BITS-1:0]   ask_mq;
    logic [QTY_BITS-1:0]   mq;
    logic [PRICE_BITS-1:0] bid_best_price;
    logic [QTY_BITS-1:0]   bid_best_qty;
    logic [PRICE_BITS-1:0] ask_best_price;
    logic [QTY_BITS-1:0]   ask_best_qty;

    assign load_out    = (state_reg == S_DONE) && (!book_valid_reg || !book_stall);
    assign order_stall = !((state_reg == S_IDLE) || load_out);
    assign accept      = order_valid && !order_stall;
    assign book_valid  = book_valid_reg;
    assign book        = book_reg;

    assign first  = (state_reg == S_OP1);
    assign second = (state_reg == S_OP2);

    assign o_price = PRICE_BITS'(item_reg.order_price);
    assign o_qty   = QTY_BITS'(item_reg.order_qty);
    assign c_qty   = QTY_BITS'(item_reg.cancel_qty);
    assign n_price = PRICE_BITS'(item_reg.new_price);
    assign n_qty   = QTY_BITS'(item_reg.new_qty);

    assign part_cancel = (item_reg.func == FN_CANCEL) && (c_qty < o_qty);

    assign cur_add   = second || (item_reg.func == FN_ADD);
    assign cur_side  = second ? item_reg.new_side : item_reg.order_side;
    assign cur_price = second ? n_price : o_price;
    assign cur_amt   = second ? n_qty : (part_cancel ? c_qty : o_qty);

    assign look = (cur_side == SIDE_ASK) ? ask_look : bid_look;
    assign mq   = (cur_side == SIDE_ASK) ? ask_mq : bid_mq;

    assign sum      = {1'b0, mq} + {1'b0, cur_amt};
    assign sat      = sum[QTY_BITS] ? '1 : sum[QTY_BITS-1:0];
    assign cur_drop = (cur_amt >= mq);

    // cur_lvl also carries the new quantity into the cells
    always_comb
    begin
        if (cur_add)
        begin
            if (look.found)
            begin
                cur_status = ST_OK;
                cur_lvl    = sat;
            end
            else if (look.full)
            begin
                cur_status = ST_FULL;
                cur_lvl    = '0;
            end
            else
            begin
                cur_status = ST_OK;
                cur_lvl    = cur_amt;
            end
        end
        else
        begin
            if (look.found)
            begin
                cur_status = ST_OK;
                cur_lvl    = cur_drop ? '0 : (mq - cur_amt);
            end
            else
            begin
                cur_status = ST_MISSING;
                cur_lvl    = '0;
            end
        end
    end

    assign bid_cmd.en   = (first || second) && (cur_side == SIDE_BID);
    assign bid_cmd.add  = cur_add;
    assign bid_cmd.drop = cur_drop;
    assign ask_cmd.en   = (first || second) && (cur_side == SIDE_ASK);
    assign ask_cmd.add  = cur_add;
    assign ask_cmd.drop = cur_drop;

    obpl_side #(
        .LEVELS     (LEVELS),
        .PRICE_BITS (PRICE_BITS),
        .QTY_BITS   (QTY_BITS),
        .ASK        (SIDE_BID)
    ) u_bid (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (bid_cmd),
        .key_price  (cur_price),
        .key_qty    (cur_lvl),
        .look       (bid_look),
        .match_qty  (bid_mq),
        .best_price (bid_best_price),
        .best_qty   (bid_best_qty)
    );

    obpl_side #(
        .LEVELS     (LEVELS),
        .PRICE_BITS (PRICE_BITS),
        .QTY_BITS   (QTY_BITS),
        .ASK        (SIDE_ASK)
    ) u_ask (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (ask_cmd),
        .key_price  (cur_price),
        .key_qty    (cur_lvl),
        .look       (ask_look),
        .match_qty  (ask_mq),
        .best_price (ask_best_price),
        .best_qty   (ask_best_qty)
    );

    always_comb
    begin
        state_next      = state_reg;
        book_valid_next = book_valid_reg;
        book_next       = book_reg;
        res_status_next = res_status_reg;
        res_lvl_next    = res_lvl_reg;
        res_rem_next    = res_rem_reg;

        if (book_valid_reg && !book_stall)
        begin
            book_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_OP1;
                end
            end
            S_OP1:
            begin
                res_status_next = cur_status;
                res_lvl_next    = cur_lvl;
                unique case (item_reg.func)
                    FN_ADD:     res_rem_next = (cur_status == ST_OK) ? o_qty : '0;
                    FN_DELETE:  res_rem_next = '0;
                    FN_CANCEL:  res_rem_next = part_cancel ? (o_qty - c_qty) : '0;
                    FN_REPLACE: res_rem_next = '0;
                endcase
                state_next = (item_reg.func == FN_REPLACE) ? S_OP2 : S_DONE;
            end
            S_OP2:
            begin
                res_status_next = (res_status_reg != ST_OK) ? res_status_reg : cur_status;
                res_lvl_next    = cur_lvl;
                res_rem_next    = (cur_status == ST_OK) ? n_qty : '0;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    book_valid_next          = 1'b1;
                    book_next.status         = res_status_reg;
                    book_next.remaining_qty  = FIELD_W'(res_rem_reg);
                    book_next.level_qty      = FIELD_W'(res_lvl_reg);
                    book_next.best_bid_price = FIELD_W'(bid_best_price);
                    book_next.best_bid_qty   = FIELD_W'(bid_best_qty);
                    book_next.best_ask_price = FIELD_W'(ask_best_price);
                    book_next.best_ask_qty   = FIELD_W'(ask_best_qty);
                    state_next               = accept ? S_OP1 : S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            book_valid_reg <= 1'b0;
            book_reg       <= '0;
            res_status_reg <= ST_OK;
            res_lvl_reg    <= '0;
            res_rem_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            book_valid_reg <= book_valid_next;
            book_reg       <= book_next;
            res_status_reg <= res_status_next;
            res_lvl_reg    <= res_lvl_next;
            res_rem_reg    <= res_rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= order;
        end
    end

endmodule

// ===== design/obpl_cell.sv =====
// One price level cell: holds a level and shifts to or from its neighbours.
module obpl_cell
    import obpl_pkg::*;
#(
    parameter int   PRICE_BITS = PRICE_BITS_DEF,
    parameter int   QTY_BITS   = QTY_BITS_DEF,
    parameter logic ASK        = SIDE_BID
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  obpl_cmd_t             cmd,
    input  logic                  found,
    input  logic                  full,
    input  logic [PRICE_BITS-1:0] key_price,
    input  logic [QTY_BITS-1:0]   key_qty,
    input  logic                  left_valid,
    input  logic [PRICE_BITS-1:0] left_price,
    input  logic [QTY_BITS-1:0]   left_qty,
    input  logic                  left_better,
    input  logic                  right_valid,
    input  logic [PRICE_BITS-1:0] right_price,
    input  logic [QTY_BITS-1:0]   right_qty,
    output logic                  valid,
    output logic [PRICE_BITS-1:0] price,
    output logic [QTY_BITS-1:0]   qty,
    output logic                  better,
    output logic                  match
);

    logic                  valid_reg;
    logic                  valid_next;
    logic [PRICE_BITS-1:0] price_reg;
    logic [PRICE_BITS-1:0] price_next;
    logic [QTY_BITS-1:0]   qty_reg;
    logic [QTY_BITS-1:0]   qty_next;

    assign valid  = valid_reg;
    assign price  = price_reg;
    assign qty    = qty_reg;
    assign match  = valid_reg && (price_reg == key_price);
    assign better = valid_reg && ((ASK == SIDE_ASK) ? (price_reg < key_price)
                                                    : (price_reg > key_price));

    always_comb
    begin
        valid_next = valid_reg;
        price_next = price_reg;
        qty_next   = qty_reg;
        if (cmd.en)
        begin
            if (cmd.add)
            begin
                if (found)
                begin
                    if (match)
                    begin
                        qty_next = key_qty;
                    end
                end
                else if (!full && !better)
                begin
                    if (left_better)
                    begin
                        valid_next = 1'b1;
                        price_next = key_price;
                        qty_next   = key_qty;
                    end
                    else
                    begin
                        valid_next = left_valid;
                        price_next = left_price;
                        qty_next   = left_qty;
                    end
                end
            end
            else if (found)
            begin
                if (cmd.drop)
                begin
                    if (!better)
                    begin
                        valid_next = right_valid;
                        price_next = right_price;
                        qty_next   = right_qty;
                    end
                end
                else if (match)
                begin
                    qty_next = key_qty;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        price_reg <= price_next;
        qty_reg   <= qty_next;
    end

endmodule

// ===== design/obpl_side.sv =====
// Sorted chain of level cells for one side of the book, with lookup and best level.
module obpl_side
    import obpl_pkg::*;
#(
    parameter int   LEVELS     = LEVELS_DEF,
    parameter int   PRICE_BITS = PRICE_BITS_DEF,
    parameter int   QTY_BITS   = QTY_BITS_DEF,
    parameter logic ASK        = SIDE_BID
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  obpl_cmd_t             cmd,
    input  logic [PRICE_BITS-1:0] key_price,
    input  logic [QTY_BITS-1:0]   key_qty,
    output obpl_look_t            look,
    output logic [QTY_BITS-1:0]   match_qty,
    output logic [PRICE_BITS-1:0] best_price,
    output logic [QTY_BITS-1:0]   best_qty
);

    logic                  cell_valid  [LEVELS];
    logic [PRICE_BITS-1:0] cell_price  [LEVELS];
    logic [QTY_BITS-1:0]   cell_qty    [LEVELS];
    logic                  cell_better [LEVELS];
    logic                  cell_match  [LEVELS];

    logic                  lv [LEVELS];
    logic [PRICE_BITS-1:0] lp [LEVELS];
    logic [QTY_BITS-1:0]   lq [LEVELS];
    logic                  lb [LEVELS];
    logic                  rv [LEVELS];
    logic [PRICE_BITS-1:0] rp [LEVELS];
    logic [QTY_BITS-1:0]   rq [LEVELS];

    logic found;

    genvar i;
    generate
        for (i = 0; i < LEVELS; i++)
        begin : g_cell
            if (i == 0)
            begin : g_head
                assign lv[i] = 1'b0;
                assign lp[i] = '0;
                assign lq[i] = '0;
                assign lb[i] = 1'b1;
            end
            else
            begin : g_left
                assign lv[i] = cell_valid[i-1];
                assign lp[i] = cell_price[i-1];
                assign lq[i] = cell_qty[i-1];
                assign lb[i] = cell_better[i-1];
            end

            if (i == LEVELS - 1)
            begin : g_tail
                assign rv[i] = 1'b0;
                assign rp[i] = '0;
                assign rq[i] = '0;
            end
            else
            begin : g_right
                assign rv[i] = cell_valid[i+1];
                assign rp[i] = cell_price[i+1];
                assign rq[i] = cell_qty[i+1];
            end

            obpl_cell #(
                .PRICE_BITS (PRICE_BITS),
                .QTY_BITS   (QTY_BITS),
                .ASK        (ASK)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd),
                .found       (found),
                .full        (look.full),
                .key_price   (key_price),
                .key_qty     (key_qty),
                .left_valid  (lv[i]),
                .left_price  (lp[i]),
                .left_qty    (lq[i]),
                .left_better (lb[i]),
                .right_valid (rv[i]),
                .right_price (rp[i]),
                .right_qty   (rq[i]),
                .valid       (cell_valid[i]),
                .price       (cell_price[i]),
                .qty         (cell_qty[i]),
                .better      (cell_better[i]),
                .match       (cell_match[i])
            );
        end
    endgenerate

    // prices are unique, so at most one cell matches
    always_comb
    begin
        found     = 1'b0;
        match_qty = '0;
        for (int k = 0; k < LEVELS; k++)
        begin
            found     = found | cell_match[k];
            match_qty = match_qty | (cell_match[k] ? cell_qty[k] : '0);
        end
    end

    assign look.found = found;
    assign look.full  = cell_valid[LEVELS-1];
    assign best_price = cell_valid[0] ? cell_price[0] : '0;
    assign best_qty   = cell_valid[0] ? cell_qty[0] : '0;

endmodule
